// File: design/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg
// Shared constants and types of the smallest-prime-factor factorizer: table
// depth, address and value widths, and the request bundle of the table RAM.
// ----------------------------------------------------------------------------
package spf_pkg;

    // Depth of the factor table; only 16-bit values can arrive, so it is capped.
    localparam int unsigned TABLE_SIZE = 65536;
    localparam int unsigned TBL_DEPTH  = (TABLE_SIZE < 65536) ? TABLE_SIZE : 65536;
    localparam int unsigned ADDR_W     = $clog2(TBL_DEPTH);

    // Field widths of the stream items.
    localparam int unsigned VAL_W = 16;
    localparam int unsigned EXP_W = 5;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [VAL_W-1:0]  t_val;
    typedef logic [EXP_W-1:0]  t_exp;

    // One write port and one read port of the table RAM.
    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_val  wdata;
        t_addr raddr;
    } t_mem_req;

endpackage

// File: design/spf_mem.sv
// ----------------------------------------------------------------------------
// spf_mem
// Smallest-prime-factor table RAM: one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
module spf_mem
    import spf_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_val     o_rdata
);

    t_val r_mem [TBL_DEPTH];
    t_val r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/spf_div.sv
// ----------------------------------------------------------------------------
// spf_div
// Iterative restoring divider: one quotient bit per cycle, giving a 16-bit
// quotient.
// ----------------------------------------------------------------------------
module spf_div
    import spf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_val i_dividend,
    input  t_val i_divisor,
    output logic o_busy,
    output logic o_done,
    output t_val o_quotient
);

    localparam logic [3:0] LAST_STEP = 4'(VAL_W - 1);

    logic       r_busy;
    logic       r_done;
    logic [3:0] r_cnt;
    t_val       r_rem;
    t_val       r_quo;
    t_val       r_div;

    logic [VAL_W:0] rem_sh;
    logic [VAL_W:0] diff;
    logic           fits;
    t_val           n_rem;
    t_val           n_quo;

    // One shift-subtract step.
    always_comb begin
        rem_sh = {r_rem, r_quo[VAL_W-1]};
        diff   = rem_sh - {1'b0, r_div};
        fits   = (rem_sh >= {1'b0, r_div});
        n_rem  = fits ? diff[VAL_W-1:0] : rem_sh[VAL_W-1:0];
        n_quo  = {r_quo[VAL_W-2:0], fits};
    end

    // Step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and partial-result registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    // A new division is never started on top of a running one.
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

endmodule

// File: design/spf_sieve.sv
// ----------------------------------------------------------------------------
// spf_sieve
// Table builder: clears the table, then runs the Eratosthenes sieve, writing
// each still-empty entry with the prime that first reaches it.
// ----------------------------------------------------------------------------
module spf_sieve
    import spf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_val     i_rdata,
    output t_mem_req o_req,
    output logic     o_done
);

    typedef logic [ADDR_W:0] t_cnt;

    localparam t_cnt DEPTH_CNT = t_cnt'(TBL_DEPTH);
    localparam t_cnt LAST_CNT  = t_cnt'(TBL_DEPTH - 1);
    localparam t_cnt FIRST_P   = t_cnt'(2);

    typedef enum logic [5:0] {
        SV_CLEAR   = 6'b000001,
        SV_OUT_RD  = 6'b000010,
        SV_OUT_CHK = 6'b000100,
        SV_IN_RD   = 6'b001000,
        SV_IN_CHK  = 6'b010000,
        SV_DONE    = 6'b100000
    } t_sv_state;

    t_sv_state r_state, n_state;
    t_cnt      r_i, n_i;
    t_cnt      r_j, n_j;

    // Sequencer: clearing sweep, then the outer scan over candidates and the
    // inner walk over multiples, each step a read followed by a check.
    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        o_req.we    = 1'b0;
        o_req.waddr = r_j[ADDR_W-1:0];
        o_req.wdata = '0;
        o_req.raddr = r_i[ADDR_W-1:0];
        unique case (r_state)
            SV_CLEAR: begin
                o_req.we = 1'b1;
                n_j      = r_j + t_cnt'(1);
                if (r_j == LAST_CNT) begin
                    n_i     = FIRST_P;
                    n_state = SV_OUT_RD;
                end
            end
            SV_OUT_RD: begin
                if (r_i >= DEPTH_CNT) begin
                    n_state = SV_DONE;
                end else begin
                    n_state = SV_OUT_CHK;
                end
            end
            SV_OUT_CHK: begin
                if (i_rdata == '0) begin
                    // A prime: mark itself and walk its multiples.
                    o_req.we    = 1'b1;
                    o_req.waddr = r_i[ADDR_W-1:0];
                    o_req.wdata = VAL_W'(r_i);
                    n_j         = r_i + r_i;
                    n_state     = SV_IN_RD;
                end else begin
                    n_i     = r_i + t_cnt'(1);
                    n_state = SV_OUT_RD;
                end
            end
            SV_IN_RD: begin
                o_req.raddr = r_j[ADDR_W-1:0];
                if (r_j >= DEPTH_CNT) begin
                    n_i     = r_i + t_cnt'(1);
                    n_state = SV_OUT_RD;
                end else begin
                    n_state = SV_IN_CHK;
                end
            end
            SV_IN_CHK: begin
                o_req.wdata = VAL_W'(r_i);
                o_req.we    = (i_rdata == '0);
                n_j         = r_j + r_i;
                n_state     = SV_IN_RD;
            end
            SV_DONE: begin
                n_state = SV_DONE;
            end
            default: begin
                n_state = SV_CLEAR;
            end
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SV_CLEAR;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    assign o_done = (r_state == SV_DONE);

endmodule

// File: design/smallest_prime_factor_factorizer.sv
// After reset: a clearing sweep over the whole table, then the sieve, reading and checking
// each candidate and each multiple visited; no request is taken before.
// Per value: the request is taken in idle, its smallest factor is looked up, then each
// prime power is removed in the shared divider and checked against the table, and each
// result is emitted; one value is in work at a time.
// Reset (synchronous, active low) restarts the table build from scratch.
// ----------------------------------------------------------------------------
// smallest_prime_factor_factorizer
// Factorizes 16-bit values through a smallest-prime-factor table: one result
// per distinct prime, ascending, with its exponent; zero and one give one empty result.
// ----------------------------------------------------------------------------
module smallest_prime_factor_factorizer
    import spf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] value
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [15:0] prime_factor, [20:16] exponent, zero above
    output logic        o_m_tlast,   // last_factor
    output logic        o_m_tuser    // value_is_prime
);

    localparam logic [VAL_W:0] DEPTH_V = (VAL_W + 1)'(TBL_DEPTH);
    localparam t_val           ONE_V   = t_val'(1);

    typedef enum logic [4:0] {
        Q_IDLE  = 5'b00001,
        Q_FIRST = 5'b00010,
        Q_DIV   = 5'b00100,
        Q_CHK   = 5'b01000,
        Q_EMIT  = 5'b10000
    } t_q_state;

    t_q_state r_state, n_state;
    t_val     r_cur, n_cur;
    t_val     r_p, n_p;
    t_val     r_np, n_np;
    t_exp     r_e, n_e;
    logic     r_last, n_last;
    logic     r_isp, n_isp;

    logic     r_o_valid;
    t_val     r_o_prime;
    t_exp     r_o_exp;
    logic     r_o_last;
    logic     r_o_isp;

    t_mem_req sv_req, q_req, mem_req;
    t_val     rdata;
    logic     sieve_done;

    logic     div_start;
    t_val     div_divisor;
    logic     div_busy;
    logic     div_done;
    t_val     quotient;

    logic     out_free;
    logic     s_accept;
    logic     load_out;

    // Table builder and the table itself.
    spf_sieve u_sieve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rdata (rdata),
        .o_req   (sv_req),
        .o_done  (sieve_done)
    );

    assign mem_req = sieve_done ? q_req : sv_req;

    spf_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    // Shared divider strips one prime at a time.
    spf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_cur),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign out_free   = !r_o_valid || i_m_tready;
    assign o_s_tready = sieve_done && (r_state == Q_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign load_out   = (r_state == Q_EMIT) && out_free;

    // Query sequencer.
    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_p         = r_p;
        n_np        = r_np;
        n_e         = r_e;
        n_last      = r_last;
        n_isp       = r_isp;
        div_start   = 1'b0;
        div_divisor = r_p;
        q_req.we    = 1'b0;
        q_req.waddr = '0;
        q_req.wdata = '0;
        q_req.raddr = r_cur[ADDR_W-1:0];
        unique case (r_state)
            Q_IDLE: begin
                q_req.raddr = i_s_tdata[ADDR_W-1:0];
                if (s_accept) begin
                    n_cur = i_s_tdata;
                    if ((i_s_tdata < t_val'(2)) || ({1'b0, i_s_tdata} >= DEPTH_V)) begin
                        // Zero, one or beyond the table: one empty result.
                        n_p     = '0;
                        n_e     = '0;
                        n_last  = 1'b1;
                        n_isp   = 1'b0;
                        n_state = Q_EMIT;
                    end else begin
                        n_state = Q_FIRST;
                    end
                end
            end
            Q_FIRST: begin
                n_p         = rdata;
                n_isp       = (rdata == r_cur);
                n_e         = '0;
                div_start   = 1'b1;
                div_divisor = rdata;
                n_state     = Q_DIV;
            end
            Q_DIV: begin
                q_req.raddr = quotient[ADDR_W-1:0];
                if (div_done) begin
                    n_cur   = quotient;
                    n_e     = r_e + t_exp'(1);
                    n_state = Q_CHK;
                end
            end
            Q_CHK: begin
                if (r_cur == ONE_V) begin
                    n_last  = 1'b1;
                    n_state = Q_EMIT;
                end else if (rdata == r_p) begin
                    div_start = 1'b1;
                    n_state   = Q_DIV;
                end else begin
                    n_np    = rdata;
                    n_last  = 1'b0;
                    n_state = Q_EMIT;
                end
            end
            Q_EMIT: begin
                div_divisor = r_np;
                if (out_free) begin
                    if (r_last) begin
                        n_state = Q_IDLE;
                    end else begin
                        // Move on to the next larger prime.
                        n_p       = r_np;
                        n_e       = '0;
                        div_start = 1'b1;
                        n_state   = Q_DIV;
                    end
                end
            end
            default: begin
                n_state = Q_IDLE;
            end
        endcase
    end

    // Sequencer control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= Q_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working value, current prime and exponent.
    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_p    <= n_p;
        r_np   <= n_np;
        r_e    <= n_e;
        r_last <= n_last;
        r_isp  <= n_isp;
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load_out) begin
            r_o_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_prime <= r_p;
            r_o_exp   <= r_e;
            r_o_last  <= r_last;
            r_o_isp   <= r_isp;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {3'b000, r_o_exp, r_o_prime};
    assign o_m_tlast  = r_o_last;
    assign o_m_tuser  = r_o_isp;

    // Requests are taken only once the table is built.
    a_ready_after_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> sieve_done)
        else $error("request taken before the table was complete");

    // An empty result is always the only and last one, with no exponent.
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[15:0] == '0))
            |-> (o_m_tlast && (o_m_tdata[20:16] == '0) && !o_m_tuser))
        else $error("malformed empty result");

    // The divider is never left running while the block waits for a request.
    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == Q_IDLE) |-> !div_busy)
        else $error("divider busy while idle");

endmodule

// File: tb/smallest_prime_factor_factorizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smallest_prime_factor_factorizer_tb
// Self-checking bench for the smallest-prime-factor factorizer. A queue of
// values, a directed set followed by random ones, is offered in bursts with
// random gaps. The bench keeps its own sieved factor table and predicts the
// stream of (prime, exponent) results for every request taken. The result
// side stalls on a changing pattern and holds off once for a long stretch so
// that the block backs up into its input.
// ----------------------------------------------------------------------------
module smallest_prime_factor_factorizer_tb;
    import spf_pkg::*;

    // Timing of the run.
    localparam int unsigned CLK_HALF      = 10;
    localparam int unsigned RESET_CYCLES  = 8;
    localparam int unsigned RANDOM_VALUES = 240;
    localparam int unsigned DRAIN_CYCLES  = 400;
    // The limit must cover the table build after reset.
    localparam int unsigned IDLE_LIMIT    = 2000000;
    localparam int unsigned HOLD_AFTER    = 40;
    localparam int unsigned HOLD_CYCLES   = 3000;

    typedef enum int unsigned {
        KIND_UNIFORM,
        KIND_SMALL,
        KIND_SMOOTH
    } t_value_kind;

    typedef enum int unsigned {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC
    } t_rx_mode;

    // One factor result as it leaves the block.
    typedef struct packed {
        t_val prime_factor;
        t_exp exponent;
        logic last_factor;
        logic value_is_prime;
    } t_factor_result;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    t_val           pending_values[$];
    t_factor_result expected_factors[$];
    t_val           factor_lut [TBL_DEPTH];
    int unsigned    small_primes [6] = '{2, 3, 5, 7, 11, 13};

    logic        request_taken     = 1'b0;
    int unsigned requests_accepted = 0;
    int unsigned mismatch_count    = 0;
    int unsigned idle_cycles       = 0;

    smallest_prime_factor_factorizer i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser)
    );

    always #(CLK_HALF) clk = ~clk;

    // Walk the value down by its smallest factors and queue one result per
    // distinct prime. Values below two give a single empty result.
    task automatic predict_factors(input t_val value);
        int unsigned    n;
        int unsigned    p;
        int unsigned    e;
        logic           value_prime;
        t_factor_result r;
        n = value;
        if (n < 2 || n >= TBL_DEPTH) begin
            r = '{prime_factor: '0, exponent: '0, last_factor: 1'b1, value_is_prime: 1'b0};
            expected_factors = {expected_factors, r};
            return;
        end
        value_prime = (factor_lut[n] == n);
        while (n > 1) begin
            p = factor_lut[n];
            e = 0;
            while (n > 1 && factor_lut[n] == p) begin
                n = n / p;
                e++;
            end
            r.prime_factor   = t_val'(p);
            r.exponent       = t_exp'(e);
            r.last_factor    = (n <= 1);
            r.value_is_prime = value_prime;
            expected_factors = {expected_factors, r};
        end
    endtask

    // Monitor on both sides: take requests, predict their results, check results.
    always @(posedge clk) begin : check_results
        t_factor_result want;
        request_taken <= s_tvalid && s_tready;
        if (s_tvalid && s_tready) begin
            predict_factors(s_tdata);
            requests_accepted <= requests_accepted + 1;
        end
        if (m_tvalid && m_tready) begin
            if (expected_factors.size() == 0) begin
                $error("unexpected result: prime_factor %0d exponent %0d",
                       m_tdata[15:0], m_tdata[20:16]);
                mismatch_count++;
            end else begin
                want = expected_factors.pop_front();
                if (m_tdata[15:0] !== want.prime_factor) begin
                    $error("prime_factor: expected %0d, actual %0d",
                           want.prime_factor, m_tdata[15:0]);
                    mismatch_count++;
                end
                if (m_tdata[20:16] !== want.exponent) begin
                    $error("exponent: expected %0d, actual %0d",
                           want.exponent, m_tdata[20:16]);
                    mismatch_count++;
                end
                if (m_tlast !== want.last_factor) begin
                    $error("last_factor: expected %0d, actual %0d",
                           want.last_factor, m_tlast);
                    mismatch_count++;
                end
                if (m_tuser !== want.value_is_prime) begin
                    $error("value_is_prime: expected %0d, actual %0d",
                           want.value_is_prime, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // Sender: bursts of random length separated by random gaps.
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(negedge clk) begin : drive_requests
        logic next_valid;
        t_val next_data;
        next_valid = s_tvalid;
        next_data  = s_tdata;
        if (!rst_n) begin
            next_valid = 1'b0;
        end else if (!s_tvalid || request_taken) begin
            next_valid = 1'b0;
            if (burst_left == 0 && gap_left == 0) begin
                gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 400)
                                                          : $urandom_range(0, 3);
                burst_left = $urandom_range(1, 12);
            end
            if (gap_left != 0) begin
                gap_left--;
            end else if (burst_left != 0 && pending_values.size() != 0) begin
                next_valid = 1'b1;
                next_data  = pending_values.pop_front();
                burst_left--;
            end
        end
        s_tvalid <= next_valid;
        s_tdata  <= next_data;
    end

    // Receiver: changing stall patterns, plus one long hold-off once the
    // first few dozen requests are in.
    t_rx_mode    rx_mode   = RX_ALWAYS;
    int unsigned mode_left = 0;
    int unsigned rx_phase  = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;

    always @(negedge clk) begin : drive_ready
        logic next_ready;
        next_ready = 1'b1;
        rx_phase++;
        if (hold_left != 0) begin
            hold_left--;
            next_ready = 1'b0;
        end else if (!hold_done && requests_accepted >= HOLD_AFTER) begin
            hold_done  = 1'b1;
            hold_left  = HOLD_CYCLES - 1;
            next_ready = 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(50, 1500);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_ALWAYS: next_ready = 1'b1;
                RX_RANDOM: next_ready = 1'($urandom_range(0, 1));
                default:   next_ready = (rx_phase % 5) >= 2;
            endcase
        end
        m_tready <= next_ready;
    end

    // Watchdog on cycles in which neither side moves anything.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("smallest_prime_factor_factorizer_tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned i;
        int unsigned j;
        int unsigned n;
        int unsigned p;
        t_value_kind kind;

        // Sieve the bench's own smallest-factor table.
        for (i = 0; i < TBL_DEPTH; i++) factor_lut[i] = '0;
        for (i = 2; i < TBL_DEPTH; i++) begin
            if (factor_lut[i] == 0) begin
                factor_lut[i] = t_val'(i);
                for (j = i * i; j < TBL_DEPTH; j += i)
                    if (factor_lut[j] == 0) factor_lut[j] = t_val'(i);
            end
        end

        // Directed values: zero and one, small primes and powers, the top of
        // the range, the largest 16-bit prime, a prime just above the sieve
        // bound, the largest exponent and the most distinct primes.
        pending_values = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd6, 16'd49, 16'd61,
                           16'd257, 16'd63001, 16'd65535, 16'd65521, 16'd65534,
                           16'd32768, 16'd32767, 16'd59049, 16'd16807, 16'd30030,
                           16'd65025, 16'd65280, 16'd64009, 16'hAAAA, 16'h5555,
                           16'hFFFE, 16'd0};

        // Random values: uniform, small, and products of small primes so that
        // long factor lists and high exponents come up often.
        repeat (RANDOM_VALUES) begin
            kind = t_value_kind'($urandom_range(0, 2));
            case (kind)
                KIND_UNIFORM: n = $urandom_range(0, 65535);
                KIND_SMALL:   n = $urandom_range(0, 300);
                default: begin
                    n = 1;
                    repeat ($urandom_range(1, 16)) begin
                        p = small_primes[$urandom_range(0, 5)];
                        if (n * p < TBL_DEPTH) n = n * p;
                    end
                end
            endcase
            pending_values = {pending_values, t_val'(n)};
        end

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Drain: all requests in, all results out, then a quiet stretch.
        while (pending_values.size() != 0 || s_tvalid) @(negedge clk);
        while (expected_factors.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && expected_factors.size() == 0) begin
            $display("smallest_prime_factor_factorizer_tb: PASS");
        end else begin
            $display("smallest_prime_factor_factorizer_tb: FAIL");
        end
        $finish;
    end

endmodule
